/* src/pth_pkg.sv */
// Shared types and constants for the point transform and height filter.
package pth_pkg;

    localparam int CoordW = 32;
    localparam int CoefW  = 34;
    localparam int ProdW  = 64;
    localparam int SumW   = 66;
    localparam int RndW   = 38;
    localparam int HgtW   = 39;
    localparam int RndShift = 28;

    localparam logic [63:0] QUAT_RESET = 64'h7FFF_0000_0000_0000;
    localparam logic signed [CoordW-1:0] MAX_H_RESET = 32'sd131072;
    localparam logic signed [SumW-1:0] RND_HALF = 66'sd134217728;
    localparam logic signed [HgtW-1:0] SAT_MAX = 39'sd2147483647;
    localparam logic signed [HgtW-1:0] SAT_MIN = -39'sd2147483648;

    typedef enum logic [2:0] {
        CFG_QUAT = 3'd0,
        CFG_TX   = 3'd1,
        CFG_TY   = 3'd2,
        CFG_TZ   = 3'd3,
        CFG_MIN  = 3'd4,
        CFG_MAX  = 3'd5,
        CFG_EN   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [CoordW-1:0]        tag;
        logic                     last;
    } t_point;

    typedef struct packed {
        logic signed [CoefW-1:0] cx;
        logic signed [CoefW-1:0] cy;
        logic signed [CoefW-1:0] cz;
    } t_coef;

    typedef struct packed {
        logic signed [CoordW-1:0] trans_z;
        logic signed [CoordW-1:0] min_h;
        logic signed [CoordW-1:0] max_h;
        logic                     enable;
    } t_filt;

endpackage

/* src/pth_coef.sv */
// Height row of the rotation matrix, derived from the quaternion and registered.
module pth_coef (
    input  logic           i_clk,
    input  logic [63:0]    i_quat,
    output pth_pkg::t_coef o_coef
);
    import pth_pkg::*;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] p_xz, p_wy, p_wx, p_yz, p_ww, p_zz, p_xx, p_yy;
    logic signed [32:0] d_x, d_y;
    t_coef n_coef;
    t_coef r_coef;

    always_comb begin
        qw = i_quat[63:48];
        qx = i_quat[47:32];
        qy = i_quat[31:16];
        qz = i_quat[15:0];
        p_xz = qx * qz;
        p_wy = qw * qy;
        p_wx = qw * qx;
        p_yz = qy * qz;
        p_ww = qw * qw;
        p_zz = qz * qz;
        p_xx = qx * qx;
        p_yy = qy * qy;
        d_x = 33'(p_xz) - 33'(p_wy);
        d_y = 33'(p_wx) + 33'(p_yz);
        n_coef.cx = {d_x, 1'b0};
        n_coef.cy = {d_y, 1'b0};
        n_coef.cz = CoefW'(p_ww) + CoefW'(p_zz) - CoefW'(p_xx) - CoefW'(p_yy);
    end

    // Coefficients follow configuration writes; user writes while idle, unenforced.
    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

/* src/pth_pipe.sv */
// Four-stage datapath: input capture, products, rounded sum, height test.
module pth_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pth_pkg::t_coef i_coef,
    input  pth_pkg::t_filt i_filt,
    input  logic           i_valid,
    output logic           o_ready,
    input  pth_pkg::t_point i_point,
    output logic           o_valid,
    input  logic           i_ready,
    output pth_pkg::t_point o_point,
    output logic           o_keep,
    output logic signed [31:0] o_height
);
    import pth_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    t_point r_p1, r_p2, r_p3, r_p4;
    logic signed [ProdW-1:0] r_mx, r_my, r_mz;
    logic signed [RndW-1:0]  r_rnd;
    logic                    r_keep;
    logic signed [CoordW-1:0] r_height;

    logic signed [SumW-1:0]   m_x, m_y, m_z, sum;
    logic signed [HgtW-1:0]   h_full;
    logic signed [CoordW-1:0] h_sat, h_sel;
    logic signed [RndW-1:0]   n_rnd;
    logic                     n_keep;

    // A stage takes new data when it is empty or its content moves on.
    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        m_x = i_coef.cx * r_p1.x;
        m_y = i_coef.cy * r_p1.y;
        m_z = i_coef.cz * r_p1.z;
        sum = SumW'(r_mx) + SumW'(r_my) + SumW'(r_mz) + RND_HALF;
        n_rnd = sum[SumW-1:RndShift];
        h_full = HgtW'(r_rnd) + HgtW'(i_filt.trans_z);
        priority if (h_full > SAT_MAX) begin
            h_sat = SAT_MAX[CoordW-1:0];
        end else if (h_full < SAT_MIN) begin
            h_sat = SAT_MIN[CoordW-1:0];
        end else begin
            h_sat = h_full[CoordW-1:0];
        end
        h_sel = i_filt.enable ? h_sat : r_p3.z;
        n_keep = (h_sel >= i_filt.min_h) && (h_sel <= i_filt.max_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_p1 <= i_point;
        end
        if (rdy2) begin
            r_p2 <= r_p1;
            // Floor shift by two keeps each product in 64 bits.
            r_mx <= m_x[SumW-1:2];
            r_my <= m_y[SumW-1:2];
            r_mz <= m_z[SumW-1:2];
        end
        if (rdy3) begin
            r_p3  <= r_p2;
            r_rnd <= n_rnd;
        end
        if (rdy4) begin
            r_p4     <= r_p3;
            r_keep   <= n_keep;
            r_height <= h_sel;
        end
    end

    assign o_valid  = r_v4;
    assign o_point  = r_p4;
    assign o_keep   = r_keep;
    assign o_height = r_height;

    a_fill_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_v4) |=> r_v4)
        else $error("item in stage three did not move to the output register");

    a_move_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rdy3) |=> r_v3)
        else $error("item in stage two was lost");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !i_ready) |-> !o_ready)
        else $error("full pipeline accepted an item under stall");

endmodule

/* src/point_transform_height_filter_core.sv */
// Top level: configuration registers and the point transform and height filter pipeline.
// Each item passes the capture, product, rounded-sum and height-test registers in order.
// One item per cycle unless the output stalls; four stages, one of them multiplies.
// An output stall holds the full stages up to the first empty one; the others still move.
// Synchronous active-low reset empties the pipeline and loads the default configuration:
// identity quaternion, zero translation, window 0 to 131072, transform disabled.
module point_transform_height_filter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [31:0]        i_point_tag,
    input  logic               i_in_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_keep,
    output logic signed [31:0] o_kept_x,
    output logic signed [31:0] o_kept_y,
    output logic signed [31:0] o_kept_z,
    output logic [31:0]        o_kept_tag,
    output logic signed [31:0] o_height_used,
    output logic               o_out_last
);
    import pth_pkg::*;

    logic [63:0] r_quat;
    t_filt       r_filt;
    t_coef       coef;
    t_point      in_point, out_point;

    // Translation x and y do not affect the height, so those writes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat         <= QUAT_RESET;
            r_filt.trans_z <= '0;
            r_filt.min_h   <= '0;
            r_filt.max_h   <= MAX_H_RESET;
            r_filt.enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_QUAT: r_quat         <= i_cfg_data;
                CFG_TX:   ;
                CFG_TY:   ;
                CFG_TZ:   r_filt.trans_z <= i_cfg_data[31:0];
                CFG_MIN:  r_filt.min_h   <= i_cfg_data[31:0];
                CFG_MAX:  r_filt.max_h   <= i_cfg_data[31:0];
                CFG_EN:   r_filt.enable  <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    pth_coef u_coef (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .o_coef (coef)
    );

    always_comb begin
        in_point.x    = i_point_x;
        in_point.y    = i_point_y;
        in_point.z    = i_point_z;
        in_point.tag  = i_point_tag;
        in_point.last = i_in_last;
    end

    pth_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (coef),
        .i_filt   (r_filt),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_point  (in_point),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_point  (out_point),
        .o_keep   (o_keep),
        .o_height (o_height_used)
    );

    assign o_kept_x   = out_point.x;
    assign o_kept_y   = out_point.y;
    assign o_kept_z   = out_point.z;
    assign o_kept_tag = out_point.tag;
    assign o_out_last = out_point.last;

endmodule
